FILE: rtl/ptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared constants, payload types and helpers for the four-level table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    // table memory geometry
    localparam int MEM_WORDS     = 4096;
    localparam int MEM_ADDR_W    = $clog2(MEM_WORDS);
    localparam int IDX_W         = 9;
    localparam int TABLE_ENTRIES = 1 << IDX_W;
    localparam int TABLES        = MEM_WORDS / TABLE_ENTRIES;

    localparam int WORD_W        = 64;
    localparam int WORD_INDEX_W  = 12;
    localparam int VA_W          = 48;
    localparam int PA_W          = 52;
    localparam int FRAME_W       = 40;

    // entry layout
    localparam int BIT_PRESENT   = 0;
    localparam int BIT_PAGE_SIZE = 7;
    localparam int PAGE_SHIFT    = 12;
    localparam int MID_SHIFT     = 21;
    localparam int HUGE_SHIFT    = 30;

    // configuration port
    localparam int CFG_ADDR_W    = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int REG_ROOT_FRAME = 0;

    typedef enum logic
    {
        OP_WRITE     = 1'b0,
        OP_TRANSLATE = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        LVL_PT   = 2'd0,
        LVL_PD   = 2'd1,
        LVL_PDPT = 2'd2,
        LVL_ROOT = 2'd3
    } level_t;

    typedef struct packed
    {
        logic                    opcode;
        logic [WORD_INDEX_W-1:0] word_index;
        logic [WORD_W-1:0]       write_data;
        logic [VA_W-1:0]         virtual_address;
    } cmd_t;

    typedef struct packed
    {
        logic [PA_W-1:0] physical_address;
        logic            mapped;
    } result_t;

    typedef struct packed
    {
        logic                  we;
        logic [MEM_ADDR_W-1:0] waddr;
        logic [WORD_W-1:0]     wdata;
        logic                  re;
        logic [MEM_ADDR_W-1:0] raddr;
    } ram_req_t;

    // 9-bit table index of a virtual address for a given level
    function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                  input level_t lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_ROOT: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            LVL_PT:   idx = va[20:12];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

    // word address of entry idx in table at frame (frame must be in range)
    function automatic logic [MEM_ADDR_W-1:0] entry_addr(input logic [FRAME_W-1:0] frame,
                                                         input logic [IDX_W-1:0] idx);
        return (MEM_ADDR_W'(frame) << IDX_W) | MEM_ADDR_W'(idx);
    endfunction

    function automatic logic frame_ok(input logic [FRAME_W-1:0] frame);
        return frame < FRAME_W'(TABLES);
    endfunction

endpackage

FILE: rtl/four_level_page_table_walker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// Four-level page table walker with its own 4096-word table memory.
// ----------------------------------------------------------------------------
// After reset the block zeroes its table memory, one word per cycle, and holds
// busy high until the clear is done (register writes are taken meanwhile). A
// write command is taken from idle and busy stays low. A translate command
// reads one table word per level from the single-port-read memory until a
// leaf, an absent entry or an out-of-range table ends the walk; for an
// out-of-range root table no word is read and busy stays low. Otherwise busy
// is high until the cycle in which the result is shown with done. done lasts
// exactly one cycle and cannot be held off by the receiver, so it must be
// captured then. Only translate commands produce a result word.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              start,
    input  ptw_pkg::cmd_t                     cmd,
    output logic                              busy,

    output logic                              done,
    output ptw_pkg::result_t                  result,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ptw_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [ptw_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [ptw_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [ptw_pkg::FRAME_W-1:0] root_frame_reg, root_frame_next;
    logic                        cfg_sel_root;
    ptw_pkg::ram_req_t           ram_req;
    logic [ptw_pkg::WORD_W-1:0]  ram_rdata;

    // registers sit at 8-byte spacing; bit 3 picks the register
    assign cfg_sel_root = (paddr[3] == 1'(ptw_pkg::REG_ROOT_FRAME));
    assign pready       = 1'b1;

    always_comb
    begin
        root_frame_next = root_frame_reg;
        if (psel && penable && pwrite && cfg_sel_root)
        begin
            root_frame_next = pwdata[ptw_pkg::FRAME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_frame_reg <= '0;
        end
        else
        begin
            root_frame_reg <= root_frame_next;
        end
    end

    assign prdata = cfg_sel_root ? ptw_pkg::CFG_DATA_W'(root_frame_reg) : '0;

    ptw_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .root_frame (root_frame_reg),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    ptw_ram u_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

FILE: rtl/ptw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_ram
// Table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptw_ram
(
    input  logic                     clk,
    input  ptw_pkg::ram_req_t        req,
    output logic [ptw_pkg::WORD_W-1:0] rdata
);

    logic [ptw_pkg::WORD_W-1:0] mem [ptw_pkg::MEM_WORDS];
    logic [ptw_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ptw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_ctrl
// Sequencer: clears the table memory after reset, stores words and walks the
// table levels from the root down, up to four, one memory read per level.
// ----------------------------------------------------------------------------
module ptw_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  ptw_pkg::cmd_t                 cmd,
    input  logic [ptw_pkg::FRAME_W-1:0]   root_frame,
    output logic                          busy,
    output logic                          done,
    output ptw_pkg::result_t              result,
    output ptw_pkg::ram_req_t             ram_req,
    input  logic [ptw_pkg::WORD_W-1:0]    ram_rdata
);

    typedef enum logic [2:0]
    {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_WALK  = 3'b100
    } state_t;

    state_t                           state_reg, state_next;
    logic [ptw_pkg::MEM_ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    ptw_pkg::level_t                  level_reg, level_next;
    logic [ptw_pkg::VA_W-1:0]         va_reg, va_next;
    logic                             done_reg, done_next;
    ptw_pkg::result_t                 result_reg, result_next;

    logic                             ent_present;
    logic                             ent_large;
    logic [ptw_pkg::FRAME_W-1:0]      ent_frame;
    ptw_pkg::level_t                  lvl_down;

    assign ent_present = ram_rdata[ptw_pkg::BIT_PRESENT];
    assign ent_large   = ram_rdata[ptw_pkg::BIT_PAGE_SIZE];
    assign ent_frame   = ram_rdata[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SHIFT];

    always_comb
    begin
        case (level_reg)
            ptw_pkg::LVL_ROOT: lvl_down = ptw_pkg::LVL_PDPT;
            ptw_pkg::LVL_PDPT: lvl_down = ptw_pkg::LVL_PD;
            ptw_pkg::LVL_PD:   lvl_down = ptw_pkg::LVL_PT;
            default:           lvl_down = ptw_pkg::LVL_PT;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        level_next   = level_reg;
        va_next      = va_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        ram_req      = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_cnt_reg;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ptw_pkg::MEM_ADDR_W'(ptw_pkg::MEM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.opcode == ptw_pkg::OP_WRITE)
                    begin
                        if (32'(cmd.word_index) < ptw_pkg::MEM_WORDS)
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = ptw_pkg::MEM_ADDR_W'(cmd.word_index);
                            ram_req.wdata = cmd.write_data;
                        end
                    end
                    else
                    begin
                        va_next = cmd.virtual_address;
                        if (ptw_pkg::frame_ok(root_frame))
                        begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = ptw_pkg::entry_addr(root_frame,
                                ptw_pkg::va_index(cmd.virtual_address, ptw_pkg::LVL_ROOT));
                            level_next    = ptw_pkg::LVL_ROOT;
                            state_next    = S_WALK;
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                    end
                end
            end

            S_WALK:
            begin
                if (!ent_present)
                begin
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = S_IDLE;
                end
                else if (level_reg == ptw_pkg::LVL_PDPT && ent_large)
                begin
                    done_next   = 1'b1;
                    result_next.mapped = 1'b1;
                    result_next.physical_address =
                        {ram_rdata[ptw_pkg::PA_W-1:ptw_pkg::HUGE_SHIFT],
                         va_reg[ptw_pkg::HUGE_SHIFT-1:0]};
                    state_next  = S_IDLE;
                end
                else if (level_reg == ptw_pkg::LVL_PD && ent_large)
                begin
                    done_next   = 1'b1;
                    result_next.mapped = 1'b1;
                    result_next.physical_address =
                        {ram_rdata[ptw_pkg::PA_W-1:ptw_pkg::MID_SHIFT],
                         va_reg[ptw_pkg::MID_SHIFT-1:0]};
                    state_next  = S_IDLE;
                end
                else if (level_reg == ptw_pkg::LVL_PT)
                begin
                    done_next   = 1'b1;
                    result_next.mapped = 1'b1;
                    result_next.physical_address =
                        {ram_rdata[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SHIFT],
                         va_reg[ptw_pkg::PAGE_SHIFT-1:0]};
                    state_next  = S_IDLE;
                end
                else if (ptw_pkg::frame_ok(ent_frame))
                begin
                    // descend: next table comes from this entry
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ptw_pkg::entry_addr(ent_frame,
                                        ptw_pkg::va_index(va_reg, lvl_down));
                    level_next    = lvl_down;
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            level_reg   <= ptw_pkg::LVL_ROOT;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            level_reg   <= level_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg     <= va_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------------
    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !result_reg.mapped |-> result_reg.physical_address == '0)
        else $error("unmapped result with nonzero address");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !done_reg)
        else $error("result word during memory clear");

    a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> ram_req.we && ram_req.wdata == '0 && !ram_req.re)
        else $error("clear pass not writing zero");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.we && ram_req.re))
        else $error("memory read and write in the same cycle");

    a_last_level_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK && level_reg == ptw_pkg::LVL_PT |=> state_reg == S_IDLE && done_reg)
        else $error("walk continued past the last level");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-level page table walker. Table words and
// translations go in through start/busy, root_frame through the APB port.
// A shadow copy of the table memory and the root frame predicts each
// translation, and every done word is compared against the oldest prediction.
// Stimulus builds whole walks (root, pointer, directory and leaf entries,
// some of them damaged) and then translates addresses that land on them.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PRINT_LIMIT    = 30;

    logic                           clk     = 1'b0;
    logic                           rst_n   = 1'b0;
    logic                           start   = 1'b0;
    ptw_pkg::cmd_t                  cmd     = '0;
    logic                           busy;
    logic                           done;
    ptw_pkg::result_t               result;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [ptw_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [ptw_pkg::CFG_DATA_W-1:0] pwdata  = '0;
    logic [ptw_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    four_level_page_table_walker_top uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow state of the walker
    logic [ptw_pkg::WORD_W-1:0]  table_shadow [ptw_pkg::MEM_WORDS];
    logic [ptw_pkg::FRAME_W-1:0] root_shadow = '0;

    ptw_pkg::cmd_t    pending_cmds [$];
    ptw_pkg::result_t expected_results [$];
    ptw_pkg::result_t predicted;
    ptw_pkg::result_t want;

    int idle_pct       = 0;
    int queued_items   = 0;
    int commands_taken = 0;
    int table_writes   = 0;
    int walks_mapped   = 0;
    int walks_unmapped = 0;
    int root_settings  = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    initial
    begin
        for (int i = 0; i < ptw_pkg::MEM_WORDS; i++)
            table_shadow[i] = '0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic logic [ptw_pkg::WORD_W-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [ptw_pkg::WORD_W-1:0] pointer_to(
        input logic [ptw_pkg::FRAME_W-1:0] frame);
        logic [ptw_pkg::WORD_W-1:0] e;
        e = '0;
        e[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SHIFT] = frame;
        e[ptw_pkg::BIT_PRESENT] = 1'b1;
        return e;
    endfunction

    // walk the shadow tables for one virtual address
    function automatic ptw_pkg::result_t walk_tables(input logic [ptw_pkg::VA_W-1:0] va);
        ptw_pkg::result_t            res;
        logic [ptw_pkg::WORD_W-1:0]  entry;
        logic [ptw_pkg::FRAME_W-1:0] frame;
        logic [ptw_pkg::IDX_W-1:0]   idx;
        int                          lvl;
        res = '0;
        frame = root_shadow;
        for (lvl = int'(ptw_pkg::LVL_ROOT); lvl >= int'(ptw_pkg::LVL_PT); lvl--)
        begin
            if (frame >= ptw_pkg::FRAME_W'(ptw_pkg::TABLES))
                return res;
            idx = va[ptw_pkg::PAGE_SHIFT + ptw_pkg::IDX_W * lvl +: ptw_pkg::IDX_W];
            entry = table_shadow[int'(frame) * ptw_pkg::TABLE_ENTRIES + int'(idx)];
            if (!entry[ptw_pkg::BIT_PRESENT])
                return res;
            if (lvl == int'(ptw_pkg::LVL_PDPT) && entry[ptw_pkg::BIT_PAGE_SIZE])
            begin
                res.physical_address = {entry[ptw_pkg::PA_W-1:ptw_pkg::HUGE_SHIFT],
                                        va[ptw_pkg::HUGE_SHIFT-1:0]};
                res.mapped = 1'b1;
                return res;
            end
            if (lvl == int'(ptw_pkg::LVL_PD) && entry[ptw_pkg::BIT_PAGE_SIZE])
            begin
                res.physical_address = {entry[ptw_pkg::PA_W-1:ptw_pkg::MID_SHIFT],
                                        va[ptw_pkg::MID_SHIFT-1:0]};
                res.mapped = 1'b1;
                return res;
            end
            if (lvl == int'(ptw_pkg::LVL_PT))
            begin
                res.physical_address = {entry[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SHIFT],
                                        va[ptw_pkg::PAGE_SHIFT-1:0]};
                res.mapped = 1'b1;
                return res;
            end
            frame = entry[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SHIFT];
        end
        return res;
    endfunction

    // ---------------- stimulus ----------------

    task automatic queue_write(input logic [ptw_pkg::WORD_INDEX_W-1:0] idx,
                               input logic [ptw_pkg::WORD_W-1:0] data);
        ptw_pkg::cmd_t c;
        c.opcode          = ptw_pkg::OP_WRITE;
        c.word_index      = idx;
        c.write_data      = data;
        c.virtual_address = ptw_pkg::VA_W'(random_word());
        pending_cmds.push_back(c);
        queued_items++;
    endtask

    task automatic queue_translate(input logic [ptw_pkg::VA_W-1:0] va);
        ptw_pkg::cmd_t c;
        c.opcode          = ptw_pkg::OP_TRANSLATE;
        c.word_index      = ptw_pkg::WORD_INDEX_W'($urandom());
        c.write_data      = random_word();
        c.virtual_address = va;
        pending_cmds.push_back(c);
        queued_items++;
    endtask

    // lay down one walk from the root (a random table if out of range) and translate addresses on it
    task automatic queue_mapping();
        logic [ptw_pkg::VA_W-1:0]    va;
        logic [ptw_pkg::VA_W-1:0]    low_mask;
        logic [ptw_pkg::FRAME_W-1:0] table_frame;
        logic [ptw_pkg::FRAME_W-1:0] next_frame;
        logic [ptw_pkg::WORD_W-1:0]  entry;
        int                          leaf_lvl;
        int                          broken_lvl;
        int                          lvl;
        int                          extra;
        va = ptw_pkg::VA_W'(random_word());
        leaf_lvl = int'($urandom_range(int'(ptw_pkg::LVL_PDPT)));
        broken_lvl = ($urandom_range(7) == 0)
                   ? int'($urandom_range(int'(ptw_pkg::LVL_ROOT), leaf_lvl)) : -1;
        table_frame = (root_shadow < ptw_pkg::FRAME_W'(ptw_pkg::TABLES))
                    ? root_shadow
                    : ptw_pkg::FRAME_W'($urandom_range(ptw_pkg::TABLES - 1));
        for (lvl = int'(ptw_pkg::LVL_ROOT); lvl >= leaf_lvl; lvl--)
        begin
            entry = random_word();
            entry[ptw_pkg::BIT_PRESENT] = 1'b1;
            next_frame = ptw_pkg::FRAME_W'($urandom_range(ptw_pkg::TABLES - 1));
            if (lvl == leaf_lvl)
            begin
                // 4K leaf ignores page size, large leaves need it
                if (lvl != int'(ptw_pkg::LVL_PT))
                    entry[ptw_pkg::BIT_PAGE_SIZE] = 1'b1;
            end
            else
            begin
                entry[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SHIFT] = next_frame;
                // root-level page size is don't-care
                if (lvl != int'(ptw_pkg::LVL_ROOT))
                    entry[ptw_pkg::BIT_PAGE_SIZE] = 1'b0;
            end
            if (lvl == broken_lvl)
            begin
                if (lvl == leaf_lvl || $urandom_range(1))
                    entry[ptw_pkg::BIT_PRESENT] = 1'b0;
                else if ($urandom_range(1))
                    entry[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SHIFT] =
                        ptw_pkg::FRAME_W'(ptw_pkg::TABLES + $urandom_range(7));
                else
                    entry[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SHIFT] =
                        ptw_pkg::FRAME_W'(random_word())
                        | (ptw_pkg::FRAME_W'(1) << $urandom_range(ptw_pkg::FRAME_W - 1, 3));
            end
            queue_write(ptw_pkg::WORD_INDEX_W'(int'(table_frame) * ptw_pkg::TABLE_ENTRIES
                        + int'(va[ptw_pkg::PAGE_SHIFT + ptw_pkg::IDX_W * lvl
                                  +: ptw_pkg::IDX_W])), entry);
            table_frame = next_frame;
        end
        low_mask = (ptw_pkg::VA_W'(1) << (ptw_pkg::PAGE_SHIFT + ptw_pkg::IDX_W * leaf_lvl))
                 - ptw_pkg::VA_W'(1);
        queue_translate(va);
        for (extra = int'($urandom_range(2)); extra > 0; extra--)
            queue_translate((va & ~low_mask) | (ptw_pkg::VA_W'(random_word()) & low_mask));
    endtask

    task automatic queue_random(input int count);
        int target;
        int pick;
        target = queued_items + count;
        while (queued_items < target)
        begin
            pick = int'($urandom_range(99));
            if (pick < 75)
                queue_mapping();
            else if (pick < 90)
                queue_write(ptw_pkg::WORD_INDEX_W'($urandom()), random_word());
            else
                queue_translate(ptw_pkg::VA_W'(random_word()));
        end
    endtask

    task automatic queue_directed();
        queue_translate('0);
        queue_translate('1);
        // root entry pointing far outside memory
        queue_write('0, '1);
        queue_translate('0);
        // root page size set, walk must still go down
        queue_write('0, pointer_to(ptw_pkg::FRAME_W'(1))
                        | (ptw_pkg::WORD_W'(1) << ptw_pkg::BIT_PAGE_SIZE));
        // 1G leaf with junk in the low base bits
        queue_write(ptw_pkg::WORD_INDEX_W'(ptw_pkg::TABLE_ENTRIES), '1);
        queue_translate(ptw_pkg::VA_W'(32'h3FFF_FFFF));
        queue_write(ptw_pkg::WORD_INDEX_W'(ptw_pkg::TABLE_ENTRIES),
                    pointer_to(ptw_pkg::FRAME_W'(2)));
        queue_write(ptw_pkg::WORD_INDEX_W'(2 * ptw_pkg::TABLE_ENTRIES), '1);
        queue_translate(ptw_pkg::VA_W'(32'h001F_FFFF));
        queue_write(ptw_pkg::WORD_INDEX_W'(2 * ptw_pkg::TABLE_ENTRIES),
                    pointer_to(ptw_pkg::FRAME_W'(3)));
        queue_write(ptw_pkg::WORD_INDEX_W'(3 * ptw_pkg::TABLE_ENTRIES), '1);
        queue_translate(ptw_pkg::VA_W'(12'hFFF));
        // absent leaf, then absent directory
        queue_write(ptw_pkg::WORD_INDEX_W'(3 * ptw_pkg::TABLE_ENTRIES),
                    ~ptw_pkg::WORD_W'(1));
        queue_translate('0);
        queue_write(ptw_pkg::WORD_INDEX_W'(2 * ptw_pkg::TABLE_ENTRIES),
                    pointer_to(ptw_pkg::FRAME_W'(3)) & ~ptw_pkg::WORD_W'(1));
        queue_translate('0);
        // table one frame past the end
        queue_write(ptw_pkg::WORD_INDEX_W'(2 * ptw_pkg::TABLE_ENTRIES),
                    pointer_to(ptw_pkg::FRAME_W'(ptw_pkg::TABLES)));
        queue_translate('0);
        // top of the address space through the last table
        queue_write(ptw_pkg::WORD_INDEX_W'(ptw_pkg::TABLE_ENTRIES - 1),
                    pointer_to(ptw_pkg::FRAME_W'(ptw_pkg::TABLES - 1)));
        queue_write(ptw_pkg::WORD_INDEX_W'(ptw_pkg::MEM_WORDS - 1), '1);
        queue_translate('1);
        queue_write('0, '0);
        queue_translate('0);
    endtask

    // ---------------- configuration ----------------

    task automatic write_root(input logic [ptw_pkg::FRAME_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ptw_pkg::CFG_ADDR_W'(ptw_pkg::REG_ROOT_FRAME * 8);
        pwdata  <= ptw_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        root_shadow = value;
        root_settings++;
    endtask

    // wait until every word is taken and every walk has reported
    task automatic settle();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [ptw_pkg::FRAME_W-1:0] root_value, input int idle,
                             input int count, input bit with_directed);
        write_root(root_value);
        idle_pct = idle;
        @(negedge clk);
        if (with_directed)
            queue_directed();
        queue_random(count);
        settle();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        run_phase('0, 0, 450, 1'b1);
        run_phase(ptw_pkg::FRAME_W'(ptw_pkg::TABLES - 1), 77, 400, 1'b0);
        run_phase('1, 0, 60, 1'b0);
        run_phase(ptw_pkg::FRAME_W'($urandom_range(1, ptw_pkg::TABLES - 2)), 28, 450, 1'b0);
        run_phase(ptw_pkg::FRAME_W'(ptw_pkg::TABLES), 77, 60, 1'b0);
        run_phase(ptw_pkg::FRAME_W'($urandom_range(ptw_pkg::TABLES - 1)), 0, 200, 1'b0);
        $display("covered %0d commands: %0d table writes, %0d walks (%0d mapped, %0d unmapped)",
                 commands_taken, table_writes, walks_mapped + walks_unmapped,
                 walks_mapped, walks_unmapped);
        $display("root frame written %0d times: first, last, just outside and all ones",
                 root_settings);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                commands_taken++;
                if (cmd.opcode == ptw_pkg::OP_TRANSLATE)
                begin
                    predicted = walk_tables(cmd.virtual_address);
                    expected_results.push_back(predicted);
                    if (predicted.mapped)
                        walks_mapped++;
                    else
                        walks_unmapped++;
                end
                else
                begin
                    table_writes++;
                    if (int'(cmd.word_index) < ptw_pkg::MEM_WORDS)
                        table_shadow[cmd.word_index] = cmd.write_data;
                end
            end
            if (!start || !busy)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    cmd   <= pending_cmds.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result word with no translate outstanding");
            else
            begin
                want = expected_results.pop_front();
                if (result.physical_address !== want.physical_address)
                    report_mismatch($sformatf("physical_address got %h want %h",
                                              result.physical_address,
                                              want.physical_address));
                if (result.mapped !== want.mapped)
                    report_mismatch($sformatf("mapped got %b want %b",
                                              result.mapped, want.mapped));
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pwrite && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles, %0d walks outstanding",
                     WATCHDOG_LIMIT, expected_results.size());
            $display("simulation failed");
            $finish;
        end
    end

endmodule

FILE: filelist.f
rtl/ptw_pkg.sv
rtl/ptw_ram.sv
rtl/ptw_ctrl.sv
rtl/four_level_page_table_walker_top.sv
verif/tb_top.sv
